[src/pct_pkg.sv]
// Shared types and constants for the pixel cluster tiler.
package pct_pkg;

    localparam int COORD_W      = 16;
    localparam int AV_W         = COORD_W + 1;
    localparam int SPAN_W       = 8;
    localparam int FLD_SPAN_W   = 4;
    localparam int REM_W        = 7;
    localparam int KEY_W        = 2 * COORD_W;
    localparam int NBIT_W       = 14;
    localparam int AREA_W       = 16;
    localparam int BITMAP_W     = 64;
    localparam int BIT_IDX_W    = 6;
    localparam int BYTES_W      = 4;
    localparam int MAX_BYTES    = 8;
    localparam int BYTE_ROUND   = 7;
    localparam int BYTE_SHIFT   = 3;
    localparam int OCNT_W       = 7;
    localparam int RECIP_SHIFT  = 24;
    localparam int RECIP_W      = 25;
    localparam int PROD_W       = COORD_W + RECIP_W;
    localparam int PIPE_DEPTH   = 5;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 136;
    localparam int OUT_PAD_W    = 5;
    localparam int OUT_USER_W   = 2;
    localparam int RAM_W        = 2 * COORD_W;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_START,
        ST_WAIT,
        ST_EMIT,
        ST_NEXT,
        ST_SET_MUL,
        ST_SET_ORG,
        ST_SET_SPAN,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic load_pixel;
        logic start_scan;
        logic take_next;
        logic set_mul;
        logic set_org;
        logic set_span;
        logic load_out;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic have_cur;
        logic out_free;
    } t_status;

endpackage

[src/pct_ram.sv]
// Generic single-port-write, registered-read RAM.
module pct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/pct_ctrl.sv]
// Controller state machine that sequences collection, scans and tile output.
module pct_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tlast,
    output logic             o_s_tready,
    output pct_pkg::t_cmd    o_cmd,
    input  pct_pkg::t_status i_status
);

    pct_pkg::t_state r_state;
    pct_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pct_pkg::ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pct_pkg::ST_COLLECT: begin
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = pct_pkg::ST_START;
                end
            end
            pct_pkg::ST_START: begin
                n_state = pct_pkg::ST_WAIT;
            end
            pct_pkg::ST_WAIT: begin
                if (i_status.scan_done) begin
                    if (i_status.have_cur) begin
                        n_state = pct_pkg::ST_EMIT;
                    end else if (i_status.found) begin
                        n_state = pct_pkg::ST_NEXT;
                    end else begin
                        n_state = pct_pkg::ST_CLEAR;
                    end
                end
            end
            pct_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.found ? pct_pkg::ST_NEXT : pct_pkg::ST_CLEAR;
                end
            end
            pct_pkg::ST_NEXT: begin
                n_state = pct_pkg::ST_SET_MUL;
            end
            pct_pkg::ST_SET_MUL: begin
                n_state = pct_pkg::ST_SET_ORG;
            end
            pct_pkg::ST_SET_ORG: begin
                n_state = pct_pkg::ST_SET_SPAN;
            end
            pct_pkg::ST_SET_SPAN: begin
                n_state = pct_pkg::ST_START;
            end
            pct_pkg::ST_CLEAR: begin
                n_state = pct_pkg::ST_COLLECT;
            end
            default: begin
                n_state = pct_pkg::ST_COLLECT;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            pct_pkg::ST_COLLECT: begin
                o_s_tready       = i_rst_n;
                o_cmd.load_pixel = i_s_tvalid && i_rst_n;
            end
            pct_pkg::ST_START: begin
                o_cmd.start_scan = 1'b1;
            end
            pct_pkg::ST_WAIT: begin
            end
            pct_pkg::ST_EMIT: begin
                o_cmd.load_out = i_status.out_free;
            end
            pct_pkg::ST_NEXT: begin
                o_cmd.take_next = 1'b1;
            end
            pct_pkg::ST_SET_MUL: begin
                o_cmd.set_mul = 1'b1;
            end
            pct_pkg::ST_SET_ORG: begin
                o_cmd.set_org = 1'b1;
            end
            pct_pkg::ST_SET_SPAN: begin
                o_cmd.set_span = 1'b1;
            end
            pct_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

[src/pct_datapath.sv]
// Pixel buffer, bounding box, tile scan pipeline and output register.
module pct_datapath #(
    parameter int MAX_ROW_SPAN = 8,
    parameter int MAX_COL_SPAN = 8,
    parameter int MAX_CELLS    = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pct_pkg::t_cmd                     i_cmd,
    output pct_pkg::t_status                  o_status,
    input  logic [pct_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [pct_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic [pct_pkg::OUT_USER_W-1:0]    o_m_tuser,
    output logic                              o_m_tlast
);

    localparam int CW     = pct_pkg::COORD_W;
    localparam int AVW    = pct_pkg::AV_W;
    localparam int SW     = pct_pkg::SPAN_W;
    localparam int FSW    = pct_pkg::FLD_SPAN_W;
    localparam int RMW    = pct_pkg::REM_W;
    localparam int KW     = pct_pkg::KEY_W;
    localparam int NBW    = pct_pkg::NBIT_W;
    localparam int ARW    = pct_pkg::AREA_W;
    localparam int BMW    = pct_pkg::BITMAP_W;
    localparam int BIW    = pct_pkg::BIT_IDX_W;
    localparam int BYW    = pct_pkg::BYTES_W;
    localparam int OCW    = pct_pkg::OCNT_W;
    localparam int RCW    = pct_pkg::RECIP_W;
    localparam int PW     = pct_pkg::PROD_W;
    localparam int PD     = pct_pkg::PIPE_DEPTH;
    localparam int PADW   = pct_pkg::OUT_PAD_W;
    localparam int ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CNT_W  = $clog2(MAX_CELLS + 1);
    localparam logic [RCW-1:0] RECIP_R =
        RCW'((64'd1 << pct_pkg::RECIP_SHIFT) / MAX_ROW_SPAN + 1);
    localparam logic [RCW-1:0] RECIP_C =
        RCW'((64'd1 << pct_pkg::RECIP_SHIFT) / MAX_COL_SPAN + 1);

    logic [CW-1:0]  in_chip;
    logic [CW-1:0]  in_row;
    logic [CW-1:0]  in_col;
    logic           full;

    logic [CNT_W-1:0] r_pix_cnt;
    logic [CW-1:0]    r_row_lo;
    logic [CW-1:0]    r_row_hi;
    logic [CW-1:0]    r_col_lo;
    logic [CW-1:0]    r_col_hi;
    logic             r_drop;
    logic [CW-1:0]    r_chip;

    logic               r_scanning;
    logic [CNT_W-1:0]   r_issue_left;
    logic [ADDR_W-1:0]  r_raddr;
    logic [PD-1:0]      r_v;
    logic               issue;
    logic               scan_done;
    logic [pct_pkg::RAM_W-1:0] rd_data;

    logic [CW-1:0]  r_dr1;
    logic [CW-1:0]  r_dc1;
    logic [PW-1:0]  r_pr2;
    logic [PW-1:0]  r_pc2;
    logic [CW-1:0]  r_dr2;
    logic [CW-1:0]  r_dc2;
    logic [CW-1:0]  q_r;
    logic [CW-1:0]  q_c;
    logic [CW-1:0]  r_qr3;
    logic [CW-1:0]  r_qc3;
    logic [RMW-1:0] r_remr3;
    logic [RMW-1:0] r_remc3;
    logic [KW-1:0]  r_key4;
    logic           r_match4;
    logic [NBW-1:0] r_nbit4;

    logic [KW-1:0]   r_cur;
    logic            r_have_cur;
    logic [KW-1:0]   r_best;
    logic            r_found;
    logic [CNT_W-1:0] r_tcnt;
    logic [BMW-1:0]  r_bm;
    logic            key_gt;

    logic [CW-1:0]  r_base_r;
    logic [CW-1:0]  r_base_c;
    logic [CW-1:0]  r_org_r;
    logic [CW-1:0]  r_org_c;
    logic [SW-1:0]  r_span_r;
    logic [SW-1:0]  r_span_c;
    logic [AVW-1:0] avail_r;
    logic [AVW-1:0] avail_c;
    logic [ARW-1:0] area;
    logic [BYW-1:0] bytes;
    logic           split;

    logic           r_out_valid;
    logic [CW-1:0]  r_o_chip;
    logic [CW-1:0]  r_o_org_r;
    logic [CW-1:0]  r_o_org_c;
    logic [FSW-1:0] r_o_span_r;
    logic [FSW-1:0] r_o_span_c;
    logic [OCW-1:0] r_o_cnt;
    logic [BMW-1:0] r_o_bm;
    logic [BYW-1:0] r_o_bytes;
    logic           r_o_split;
    logic           r_o_ovf;
    logic           r_o_last;
    logic           out_free;

    assign in_chip = i_s_tdata[CW-1:0];
    assign in_row  = i_s_tdata[2*CW-1:CW];
    assign in_col  = i_s_tdata[3*CW-1:2*CW];
    assign full    = (r_pix_cnt == CNT_W'(MAX_CELLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_pix_cnt <= '0;
            r_row_lo  <= '1;
            r_row_hi  <= '0;
            r_col_lo  <= '1;
            r_col_hi  <= '0;
            r_drop    <= 1'b0;
            r_chip    <= '0;
        end else if (i_cmd.load_pixel) begin
            if (full) begin
                r_drop <= 1'b1;
            end else begin
                if (r_pix_cnt == '0) begin
                    r_chip <= in_chip;
                end
                if (in_row < r_row_lo) begin
                    r_row_lo <= in_row;
                end
                if (in_row > r_row_hi) begin
                    r_row_hi <= in_row;
                end
                if (in_col < r_col_lo) begin
                    r_col_lo <= in_col;
                end
                if (in_col > r_col_hi) begin
                    r_col_hi <= in_col;
                end
                r_pix_cnt <= r_pix_cnt + CNT_W'(1);
            end
        end
    end

    pct_ram #(
        .WIDTH(pct_pkg::RAM_W),
        .DEPTH(MAX_CELLS)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.load_pixel && !full),
        .i_wr_addr(r_pix_cnt[ADDR_W-1:0]),
        .i_wr_data({in_row, in_col}),
        .i_rd_en  (issue),
        .i_rd_addr(r_raddr),
        .o_rd_data(rd_data)
    );

    assign issue     = r_scanning && (r_issue_left != '0);
    assign scan_done = r_scanning && (r_issue_left == '0) && (r_v == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning   <= 1'b0;
            r_issue_left <= '0;
            r_raddr      <= '0;
            r_v          <= '0;
        end else begin
            r_v <= {r_v[PD-2:0], issue};
            if (i_cmd.start_scan) begin
                r_scanning   <= 1'b1;
                r_issue_left <= r_pix_cnt;
                r_raddr      <= '0;
            end else begin
                if (scan_done) begin
                    r_scanning <= 1'b0;
                end
                if (issue) begin
                    r_issue_left <= r_issue_left - CNT_W'(1);
                    r_raddr      <= r_raddr + ADDR_W'(1);
                end
            end
        end
    end

    assign q_r = r_pr2[pct_pkg::RECIP_SHIFT +: CW];
    assign q_c = r_pc2[pct_pkg::RECIP_SHIFT +: CW];

    always_ff @(posedge i_clk) begin
        r_dr1   <= rd_data[2*CW-1:CW] - r_row_lo;
        r_dc1   <= rd_data[CW-1:0] - r_col_lo;
        r_pr2   <= PW'(r_dr1) * PW'(RECIP_R);
        r_pc2   <= PW'(r_dc1) * PW'(RECIP_C);
        r_dr2   <= r_dr1;
        r_dc2   <= r_dc1;
        r_qr3   <= q_r;
        r_qc3   <= q_c;
        r_remr3 <= RMW'(r_dr2 - CW'(q_r * CW'(MAX_ROW_SPAN)));
        r_remc3 <= RMW'(r_dc2 - CW'(q_c * CW'(MAX_COL_SPAN)));
        r_key4  <= {r_qc3, r_qr3};
        r_match4 <= r_have_cur && ({r_qc3, r_qr3} == r_cur);
        r_nbit4 <= NBW'(r_remr3) * NBW'(r_span_c) + NBW'(r_remc3);
    end

    assign key_gt = !r_have_cur || (r_key4 > r_cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found    <= 1'b0;
            r_have_cur <= 1'b0;
        end else begin
            if (i_cmd.start_scan) begin
                r_found <= 1'b0;
            end else if (r_v[PD-1] && key_gt && (!r_found || (r_key4 < r_best))) begin
                r_found <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_have_cur <= 1'b0;
            end else if (i_cmd.take_next) begin
                r_have_cur <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_scan) begin
            r_tcnt <= '0;
            r_bm   <= '0;
        end else if (r_v[PD-1]) begin
            if (key_gt && (!r_found || (r_key4 < r_best))) begin
                r_best <= r_key4;
            end
            if (r_match4) begin
                r_tcnt <= r_tcnt + CNT_W'(1);
                if (r_nbit4 < NBW'(BMW)) begin
                    r_bm <= r_bm | (BMW'(1) << (BIW'(BMW - 1) - r_nbit4[BIW-1:0]));
                end
            end
        end
        if (i_cmd.take_next) begin
            r_cur <= r_best;
        end
    end

    assign avail_r = AVW'(r_row_hi) - AVW'(r_org_r) + AVW'(1);
    assign avail_c = AVW'(r_col_hi) - AVW'(r_org_c) + AVW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_mul) begin
            r_base_r <= CW'(r_cur[CW-1:0] * CW'(MAX_ROW_SPAN));
            r_base_c <= CW'(r_cur[KW-1:CW] * CW'(MAX_COL_SPAN));
        end
        if (i_cmd.set_org) begin
            r_org_r <= r_row_lo + r_base_r;
            r_org_c <= r_col_lo + r_base_c;
        end
        if (i_cmd.set_span) begin
            r_span_r <= (avail_r >= AVW'(MAX_ROW_SPAN)) ? SW'(MAX_ROW_SPAN) : SW'(avail_r);
            r_span_c <= (avail_c >= AVW'(MAX_COL_SPAN)) ? SW'(MAX_COL_SPAN) : SW'(avail_c);
        end
    end

    assign area  = ARW'(r_span_r) * ARW'(r_span_c);
    assign bytes = (area >= ARW'(BMW)) ? BYW'(pct_pkg::MAX_BYTES)
                 : BYW'((area + ARW'(pct_pkg::BYTE_ROUND)) >> pct_pkg::BYTE_SHIFT);
    assign split = ((AVW'(r_row_hi) - AVW'(r_row_lo) + AVW'(1)) > AVW'(MAX_ROW_SPAN))
                || ((AVW'(r_col_hi) - AVW'(r_col_lo) + AVW'(1)) > AVW'(MAX_COL_SPAN));
    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_chip   <= r_chip;
            r_o_org_r  <= r_org_r;
            r_o_org_c  <= r_org_c;
            r_o_span_r <= r_span_r[FSW-1:0];
            r_o_span_c <= r_span_c[FSW-1:0];
            r_o_cnt    <= OCW'(r_tcnt);
            r_o_bm     <= r_bm;
            r_o_bytes  <= bytes;
            r_o_split  <= split;
            r_o_ovf    <= r_drop;
            r_o_last   <= !r_found;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PADW{1'b0}}, r_o_bytes, r_o_bm, r_o_cnt, r_o_span_c, r_o_span_r,
                         r_o_org_c, r_o_org_r, r_o_chip};
    assign o_m_tuser  = {r_o_ovf, r_o_split};
    assign o_m_tlast  = r_o_last;

    assign o_status.scan_done = scan_done;
    assign o_status.found     = r_found;
    assign o_status.have_cur  = r_have_cur;
    assign o_status.out_free  = out_free;

endmodule

[src/pixel_cluster_pattern_tiler_unit.sv]
// Top level of the pixel cluster tiler: controller, datapath and checks.
// Pixel words are taken one per cycle; the last word of a cluster starts a pass over the n buffered
// pixels that finds the first tile. Each non-empty tile then costs the setup states (next key,
// base multiply, origin, span), one more pass and a load of the output register once it is free,
// and a final state clears the cluster. Input is held off meanwhile, so the passes set the throughput.
// Reset (synchronous, active low) empties the cluster and the output register.
module pixel_cluster_pattern_tiler_unit #(
    parameter int MAX_ROW_SPAN = 8,
    parameter int MAX_COL_SPAN = 8,
    parameter int MAX_CELLS    = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // chip_id, pixel_row, pixel_col
    input  logic [pct_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tile_chip, tile_row_origin, tile_col_origin, tile_row_span, tile_col_span,
    // tile_pixel_count, bitmap, bitmap_bytes, zero fill
    output logic [pct_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // was_split, overflowed
    output logic [pct_pkg::OUT_USER_W-1:0] o_m_tuser,
    output logic                           o_m_tlast
);

    pct_pkg::t_cmd    cmd;
    pct_pkg::t_status status;

    pct_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .i_s_tlast (i_s_tlast),
        .o_s_tready(o_s_tready),
        .o_cmd     (cmd),
        .i_status  (status)
    );

    pct_datapath #(
        .MAX_ROW_SPAN(MAX_ROW_SPAN),
        .MAX_COL_SPAN(MAX_COL_SPAN),
        .MAX_CELLS   (MAX_CELLS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_status  (status),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    a_no_accept_at_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.scan_done |-> !(i_s_tvalid && o_s_tready))
        else $error("input word accepted while a buffer pass completes");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> status.out_free)
        else $error("tile loaded over an output word not yet taken");

    a_load_shows_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_m_tvalid)
        else $error("loaded tile not presented on the output");

    a_tile_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[62:56] != '0))
        else $error("emitted tile holds no pixel");

endmodule
